@@ sv/bprc_pkg.sv @@
// Shared types, register indexes and helpers for the barometer compensation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bprc_pkg;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [31:0] fine_temperature;
      logic signed [31:0] temperature_centi;
      logic signed [63:0] pressure_q24_8;
      logic               pressure_valid;
   } rsp_type;

   typedef struct packed {
      logic [47:0] temp;
      logic [63:0] press_a;
      logic [63:0] press_b;
      logic [15:0] press_c;
   } calib_type;

   // Pre-subtracted terms handed from front to back
   typedef struct packed {
      logic [31:0] a_term;
      logic [31:0] d_term;
      logic [20:0] p_base;
   } job_type;

   localparam logic [1:0] CSR_TEMP_CALIB    = 2'd0;
   localparam logic [1:0] CSR_PRESS_CALIB_A = 2'd1;
   localparam logic [1:0] CSR_PRESS_CALIB_B = 2'd2;
   localparam logic [1:0] CSR_PRESS_CALIB_C = 2'd3;

   localparam logic [63:0] FINE_OFFSET = 64'd128000;
   localparam logic [20:0] P_FULL      = 21'd1048576;
   localparam logic [63:0] P_SCALE     = 64'd3125;
   localparam logic [63:0] X1_BIAS     = 64'h0000_8000_0000_0000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_T0, ST_T1, ST_T2,
      ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
      ST_DIV, ST_P7, ST_P8, ST_P9, ST_SUM, ST_OUT
   } step_type;

   function automatic logic [63:0] sext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

endpackage
`default_nettype wire

@@ sv/bprc_front.sv @@
// Front end: takes raw readings, forms the first subtractions, and queues jobs.
// Depends on bprc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bprc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire bprc_pkg::req_type req_data,
   output logic                   req_full,
   input  wire logic [15:0]       t1,
   output logic                   job_valid,
   output bprc_pkg::job_type      job,
   input  wire logic              job_take
);

   bprc_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   bprc_pkg::job_type new_job;
   logic       do_push;

   always_comb begin
      new_job.a_term = {15'd0, req_data.raw_temperature[19:3]} - {15'd0, t1, 1'b0};
      new_job.d_term = {16'd0, req_data.raw_temperature[19:4]} - {16'd0, t1};
      new_job.p_base = bprc_pkg::P_FULL - {1'b0, req_data.raw_pressure};
   end

   assign req_full  = (count_ff == 2'd2);
   assign do_push   = req_push && !req_full;
   assign job_valid = (count_ff != 2'd0);
   assign job       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ job_take;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, job_take};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= new_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/bprc_div.sv @@
// Signed 64-bit divider, restoring, one quotient bit per cycle.
// Depends on nothing; quotient truncates toward zero, most negative / -1 wraps.
`timescale 1ns / 1ps
`default_nettype none
module bprc_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic [63:0]      quo
);

   logic [63:0] dvd_ff, dvd_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [63:0] rem_ff, rem_in;
   logic        sign_ff, sign_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [64:0] rem_sh;
   logic [64:0] rem_sub;

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      sign_in = sign_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, dvd_ff[63]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         sign_in = num[63] ^ den[63];
         dvd_in  = num[63] ? (64'd0 - num) : num;
         dvs_in  = den[63] ? (64'd0 - den) : den;
         rem_in  = 64'd0;
         cnt_in  = 6'd0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (!rem_sub[64]) begin
            rem_in = rem_sub[63:0];
            dvd_in = {dvd_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[63:0];
            dvd_in = {dvd_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quo  = sign_ff ? (64'd0 - dvd_ff) : dvd_ff;

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      sign_ff <= sign_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/bprc_back.sv @@
// Back end: step sequencer over one shared 32x32 multiplier and the divider.
// Depends on bprc_pkg and bprc_div.
`timescale 1ns / 1ps
`default_nettype none
module bprc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bprc_pkg::calib_type calib,
   input  wire logic                job_valid,
   input  wire bprc_pkg::job_type   job,
   output logic                     job_take,
   output logic                     rsp_empty,
   output bprc_pkg::rsp_type        rsp_data,
   input  wire logic                rsp_pop
);

   bprc_pkg::step_type step_ff, step_in;
   logic [1:0]  ph_ff, ph_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] v1_ff, v1_in;
   logic [31:0] fine_ff, fine_in;
   logic [63:0] x1_ff, x1_in;
   logic [63:0] x2_ff, x2_in;
   logic [63:0] tmp_ff, tmp_in;
   logic [63:0] p_ff, p_in;
   logic        pvalid_ff, pvalid_in;
   bprc_pkg::job_type job_ff, job_in;
   bprc_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [63:0] mul_a, mul_b;
   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;
   logic        is_mul, wb;
   logic [31:0] v2, fine_new, tc_sum;
   logic [63:0] p_s13;
   logic        pop_ok, div_start, div_done;
   logic [63:0] div_quo;

   logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, t2, t3;
   assign t2 = bprc_pkg::sext16(calib.temp[31:16]);
   assign t3 = bprc_pkg::sext16(calib.temp[47:32]);
   assign p1 = {48'd0, calib.press_a[15:0]};
   assign p2 = bprc_pkg::sext16(calib.press_a[31:16]);
   assign p3 = bprc_pkg::sext16(calib.press_a[47:32]);
   assign p4 = bprc_pkg::sext16(calib.press_a[63:48]);
   assign p5 = bprc_pkg::sext16(calib.press_b[15:0]);
   assign p6 = bprc_pkg::sext16(calib.press_b[31:16]);
   assign p7 = bprc_pkg::sext16(calib.press_b[47:32]);
   assign p8 = bprc_pkg::sext16(calib.press_b[63:48]);
   assign p9 = bprc_pkg::sext16(calib.press_c);

   assign p_s13 = 64'($signed(p_ff) >>> 13);

   // operand select per step
   always_comb begin
      is_mul = 1'b1;
      mul_a  = 64'd0;
      mul_b  = 64'd0;
      case (step_ff)
         bprc_pkg::ST_T0: begin mul_a = {32'd0, job_ff.a_term}; mul_b = t2; end
         bprc_pkg::ST_T1: begin mul_a = {32'd0, job_ff.d_term}; mul_b = {32'd0, job_ff.d_term}; end
         bprc_pkg::ST_T2: begin mul_a = tmp_ff; mul_b = t3; end
         bprc_pkg::ST_P0: begin mul_a = x1_ff; mul_b = x1_ff; end
         bprc_pkg::ST_P1: begin mul_a = tmp_ff; mul_b = p6; end
         bprc_pkg::ST_P2: begin mul_a = x1_ff; mul_b = p5; end
         bprc_pkg::ST_P3: begin mul_a = tmp_ff; mul_b = p3; end
         bprc_pkg::ST_P4: begin mul_a = x1_ff; mul_b = p2; end
         bprc_pkg::ST_P5: begin mul_a = tmp_ff; mul_b = p1; end
         bprc_pkg::ST_P6: begin mul_a = tmp_ff; mul_b = bprc_pkg::P_SCALE; end
         bprc_pkg::ST_P7: begin mul_a = p9; mul_b = p_s13; end
         bprc_pkg::ST_P8: begin mul_a = tmp_ff; mul_b = p_s13; end
         bprc_pkg::ST_P9: begin mul_a = p8; mul_b = p_ff; end
         default: is_mul = 1'b0;
      endcase
   end

   // low 64 bits of a 64x64 product in three partial products
   always_comb begin
      case (ph_ff)
         2'd0:    begin mul_x = mul_a[31:0];  mul_y = mul_b[31:0];  end
         2'd1:    begin mul_x = mul_a[31:0];  mul_y = mul_b[63:32]; end
         default: begin mul_x = mul_a[63:32]; mul_y = mul_b[31:0];  end
      endcase
      mul_p = mul_x * mul_y;
      if (ph_ff == 2'd0) begin
         prod_in = mul_p;
      end else if (ph_ff == 2'd3) begin
         prod_in = prod_ff;
      end else begin
         prod_in = prod_ff + {mul_p[31:0], 32'd0};
      end
   end

   assign wb       = is_mul && (ph_ff == 2'd3);
   assign v2       = 32'($signed(prod_ff[31:0]) >>> 14);
   assign fine_new = v1_ff + v2;
   assign tc_sum   = {fine_ff[29:0], 2'b00} + fine_ff + 32'd128;
   assign pop_ok   = !rsp_valid_ff || rsp_pop;
   assign div_start = wb && (step_ff == bprc_pkg::ST_P6);

   bprc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (x1_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      step_in      = step_ff;
      ph_in        = is_mul ? ph_ff + 2'd1 : 2'd0;
      v1_in        = v1_ff;
      fine_in      = fine_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      tmp_in       = tmp_ff;
      p_in         = p_ff;
      pvalid_in    = pvalid_ff;
      job_in       = job_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      job_take     = 1'b0;
      case (step_ff)
         bprc_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               job_in   = job;
               step_in  = bprc_pkg::ST_T0;
            end
         end
         bprc_pkg::ST_T0: if (wb) begin
            v1_in   = 32'($signed(prod_ff[31:0]) >>> 11);
            step_in = bprc_pkg::ST_T1;
         end
         bprc_pkg::ST_T1: if (wb) begin
            tmp_in  = {32'd0, 32'($signed(prod_ff[31:0]) >>> 12)};
            step_in = bprc_pkg::ST_T2;
         end
         bprc_pkg::ST_T2: if (wb) begin
            fine_in = fine_new;
            x1_in   = {{32{fine_new[31]}}, fine_new} - bprc_pkg::FINE_OFFSET;
            step_in = bprc_pkg::ST_P0;
         end
         bprc_pkg::ST_P0: if (wb) begin
            tmp_in  = prod_ff;
            step_in = bprc_pkg::ST_P1;
         end
         bprc_pkg::ST_P1: if (wb) begin
            x2_in   = prod_ff + {p4[28:0], 35'd0};
            step_in = bprc_pkg::ST_P2;
         end
         bprc_pkg::ST_P2: if (wb) begin
            x2_in   = x2_ff + {prod_ff[46:0], 17'd0};
            step_in = bprc_pkg::ST_P3;
         end
         bprc_pkg::ST_P3: if (wb) begin
            tmp_in  = 64'($signed(prod_ff) >>> 8);
            step_in = bprc_pkg::ST_P4;
         end
         bprc_pkg::ST_P4: if (wb) begin
            tmp_in  = tmp_ff + {prod_ff[51:0], 12'd0} + bprc_pkg::X1_BIAS;
            step_in = bprc_pkg::ST_P5;
         end
         bprc_pkg::ST_P5: if (wb) begin
            x1_in  = 64'($signed(prod_ff) >>> 33);
            tmp_in = {prod_ff[63:33] == 31'd0 ? 64'd0 : 64'd0} +
                     ({12'd0, job_ff.p_base, 31'd0} - x2_ff);
            if (64'($signed(prod_ff) >>> 33) == 64'd0) begin
               p_in      = 64'd0;
               pvalid_in = 1'b0;
               step_in   = bprc_pkg::ST_OUT;
            end else begin
               pvalid_in = 1'b1;
               step_in   = bprc_pkg::ST_P6;
            end
         end
         bprc_pkg::ST_P6: if (wb) begin
            step_in = bprc_pkg::ST_DIV;
         end
         bprc_pkg::ST_DIV: begin
            if (div_done) begin
               p_in    = div_quo;
               step_in = bprc_pkg::ST_P7;
            end
         end
         bprc_pkg::ST_P7: if (wb) begin
            tmp_in  = prod_ff;
            step_in = bprc_pkg::ST_P8;
         end
         bprc_pkg::ST_P8: if (wb) begin
            x1_in   = 64'($signed(prod_ff) >>> 25);
            step_in = bprc_pkg::ST_P9;
         end
         bprc_pkg::ST_P9: if (wb) begin
            x2_in   = 64'($signed(prod_ff) >>> 19);
            step_in = bprc_pkg::ST_SUM;
         end
         bprc_pkg::ST_SUM: begin
            tmp_in  = p_ff + x1_ff + x2_ff;
            step_in = bprc_pkg::ST_OUT;
         end
         bprc_pkg::ST_OUT: begin
            if (pop_ok) begin
               rsp_in.fine_temperature  = fine_ff;
               rsp_in.temperature_centi = 32'($signed(tc_sum) >>> 8);
               rsp_in.pressure_q24_8    = pvalid_ff ?
                  64'($signed(tmp_ff) >>> 8) + {p7[59:0], 4'd0} : 64'd0;
               rsp_in.pressure_valid    = pvalid_ff;
               rsp_valid_in = 1'b1;
               step_in      = bprc_pkg::ST_IDLE;
            end
         end
         default: step_in = bprc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      v1_ff     <= v1_in;
      fine_ff   <= fine_in;
      x1_ff     <= x1_in;
      x2_ff     <= x2_in;
      tmp_ff    <= tmp_in;
      p_ff      <= p_in;
      pvalid_ff <= pvalid_in;
      job_ff    <= job_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         step_ff      <= bprc_pkg::ST_IDLE;
         ph_ff        <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/barometer_raw_to_pressure_temperature.sv @@
// Top level of the barometer compensation block: calibration registers, front, back.
// Depends on bprc_pkg, bprc_front, bprc_back.
//
// Usage:
//  - Calibration: four registers written through csr_valid/csr_ready (ready is
//    always high), csr_index selects the register, csr_wdata carries the value.
//    Write them only while no reading is in flight.
//  - Readings: a transfer happens when req_push is high and req_full is low. A
//    two-entry queue holds readings waiting for the back end.
//  - Results: the oldest result sits on rsp_data while rsp_empty is low and
//    leaves on a cycle with rsp_pop high.
//  - Steps: each reading runs in the back end as 13 wide multiplies on one
//    shared 32x32 multiplier, plus the bit-serial 64-bit divider and the idle,
//    sum and output steps. When the divisor is zero the divide, the multiply
//    that forms its numerator and the multiplies after it are skipped. A new
//    reading is taken each time the back end frees up.
//  - Reset clears the queues and the calibration registers to zero.
//  - If the result is not popped, the back end holds its next result until the
//    output register frees; the input queue keeps taking readings until full.
`timescale 1ns / 1ps
`default_nettype none
module barometer_raw_to_pressure_temperature (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire bprc_pkg::req_type req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   output bprc_pkg::rsp_type      rsp_data,
   input  wire logic              rsp_pop,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [63:0]       csr_wdata
);

   bprc_pkg::calib_type calib_ff, calib_in;
   logic              job_valid, job_take;
   bprc_pkg::job_type job;

   assign csr_ready = 1'b1;

   always_comb begin
      calib_in = calib_ff;
      if (csr_valid) begin
         case (csr_index)
            bprc_pkg::CSR_TEMP_CALIB:    calib_in.temp    = csr_wdata[47:0];
            bprc_pkg::CSR_PRESS_CALIB_A: calib_in.press_a = csr_wdata;
            bprc_pkg::CSR_PRESS_CALIB_B: calib_in.press_b = csr_wdata;
            bprc_pkg::CSR_PRESS_CALIB_C: calib_in.press_c = csr_wdata[15:0];
            default:                     calib_in = calib_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '0;
      end else begin
         calib_ff <= calib_in;
      end
   end

   bprc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .t1        (calib_ff.temp[15:0]),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take)
   );

   bprc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .calib     (calib_ff),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule
`default_nettype wire

@@ sv/bprc_checker.sv @@
// Port-level checks for the barometer compensation block, bound to the top level.
// Depends on bprc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bprc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_full,
   input wire logic              rsp_empty,
   input wire bprc_pkg::rsp_type rsp_data,
   input wire logic              rsp_pop
);

   logic [31:0] tc_sum;
   assign tc_sum = {rsp_data.fine_temperature[29:0], 2'b00} +
                   rsp_data.fine_temperature + 32'd128;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input queue full after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.pressure_valid) |-> (rsp_data.pressure_q24_8 == 64'sd0))
      else $error("invalid pressure not zero");

   a_centi: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.temperature_centi == 32'($signed(tc_sum) >>> 8)))
      else $error("centi temperature does not match fine temperature");

endmodule

bind barometer_raw_to_pressure_temperature bprc_checker u_bprc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_data  (rsp_data),
   .rsp_pop   (rsp_pop)
);
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for barometer_raw_to_pressure_temperature.
// Depends on bprc_pkg and the block's RTL; drives readings and calibration, checks every result.
`timescale 1ns / 1ps
module tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 3000;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_push = 0;
   bprc_pkg::req_type req_data = '0;
   logic              req_full;
   logic              rsp_empty;
   bprc_pkg::rsp_type rsp_data;
   logic              rsp_pop = 0;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [1:0]        csr_index = bprc_pkg::CSR_TEMP_CALIB;
   logic [63:0]       csr_wdata = '0;

   barometer_raw_to_pressure_temperature dut (.*);

   always #5 clock = ~clock;

   // calibration shadow, mirrors the block's registers
   logic [47:0] cal_temp = '0;
   logic [63:0] cal_press_a = '0, cal_press_b = '0;
   logic [15:0] cal_press_c = '0;

   bprc_pkg::req_type readings_pending[$];
   bprc_pkg::rsp_type results_expected[$];
   int      errors = 0;
   int      idle_mode = 0;   // 0: receiver sparse, 1: sender sparse, 2: no idling
   int      results_seen = 0;

   function automatic bprc_pkg::rsp_type compensate(bprc_pkg::req_type r);
      logic signed [31:0] ut, t1, t2, t3, a, v1, d, v2, fine;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x1, x2, p, num;
      bprc_pkg::rsp_type o;
      ut = {12'd0, r.raw_temperature};
      t1 = {16'd0, cal_temp[15:0]};
      t2 = $signed(cal_temp[31:16]);
      t3 = $signed(cal_temp[47:32]);
      a  = ((ut >>> 3) - (t1 <<< 1)) * t2;
      v1 = a >>> 11;
      d  = (ut >>> 4) - t1;
      v2 = (((d * d) >>> 12) * t3) >>> 14;
      fine = v1 + v2;
      o.fine_temperature  = fine;
      o.temperature_centi = (fine * 5 + 128) >>> 8;

      p1 = $signed({48'd0, cal_press_a[15:0]});
      p2 = $signed(cal_press_a[31:16]);
      p3 = $signed(cal_press_a[47:32]);
      p4 = $signed(cal_press_a[63:48]);
      p5 = $signed(cal_press_b[15:0]);
      p6 = $signed(cal_press_b[31:16]);
      p7 = $signed(cal_press_b[47:32]);
      p8 = $signed(cal_press_b[63:48]);
      p9 = $signed(cal_press_c);

      x1 = fine;
      x1 = x1 - 64'sd128000;
      x2 = x1 * x1 * p6;
      x2 = x2 + ((x1 * p5) <<< 17);
      x2 = x2 + (p4 <<< 35);
      x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) <<< 12);
      x1 = ((64'sh0000_8000_0000_0000 + x1) * p1) >>> 33;
      if (x1 == 64'sd0) begin
         o.pressure_q24_8 = '0;
         o.pressure_valid = 1'b0;
      end else begin
         p   = 64'sd1048576 - $signed({44'd0, r.raw_pressure});
         num = ((p <<< 31) - x2) * 64'sd3125;
         // the one quotient that overflows wraps to itself
         p   = (num == S64_MIN && x1 == -64'sd1) ? S64_MIN : num / x1;
         x1  = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
         x2  = (p8 * p) >>> 19;
         o.pressure_q24_8 = ((p + x1 + x2) >>> 8) + (p7 <<< 4);
         o.pressure_valid = 1'b1;
      end
      return o;
   endfunction

   function automatic bit idle_now(bit sender);
      if (idle_mode == 2) return 0;
      if ((idle_mode == 0) == sender) return $urandom_range(99) < 34;
      return $urandom_range(99) < 88;
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            results_expected.push_back(compensate(req_data));
            void'(readings_pending.pop_front());
         end
         if (readings_pending.size() > 0 && !idle_now(1)) begin
            req_push <= 1'b1;
            req_data <= readings_pending[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // receiver; a long hold-off once, so the block backs up into its input
   int hold_cycles = 0;
   always @(posedge clock) begin
      bprc_pkg::rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (results_seen == 300) hold_cycles = LONG_HOLD;
            if (results_expected.size() == 0) begin
               $error("result with nothing expected");
               errors++;
            end else begin
               want = results_expected.pop_front();
               if (rsp_data.fine_temperature !== want.fine_temperature) begin
                  $error("fine_temperature expected %0d got %0d",
                         want.fine_temperature, rsp_data.fine_temperature);
                  errors++;
               end
               if (rsp_data.temperature_centi !== want.temperature_centi) begin
                  $error("temperature_centi expected %0d got %0d",
                         want.temperature_centi, rsp_data.temperature_centi);
                  errors++;
               end
               if (rsp_data.pressure_q24_8 !== want.pressure_q24_8) begin
                  $error("pressure_q24_8 expected %0d got %0d",
                         want.pressure_q24_8, rsp_data.pressure_q24_8);
                  errors++;
               end
               if (rsp_data.pressure_valid !== want.pressure_valid) begin
                  $error("pressure_valid expected %0d got %0d",
                         want.pressure_valid, rsp_data.pressure_valid);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !idle_now(0);
         end
      end
   end

   // watchdog on cycles without any transfer
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready) || hold_cycles > 0) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_calib(logic [1:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         bprc_pkg::CSR_TEMP_CALIB:    cal_temp    = value[47:0];
         bprc_pkg::CSR_PRESS_CALIB_A: cal_press_a = value;
         bprc_pkg::CSR_PRESS_CALIB_B: cal_press_b = value;
         bprc_pkg::CSR_PRESS_CALIB_C: cal_press_c = value[15:0];
         default: ;
      endcase
   endtask

   task automatic write_all(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
                            logic [15:0] pc);
      write_calib(bprc_pkg::CSR_TEMP_CALIB, {16'hFFFF, t});
      write_calib(bprc_pkg::CSR_PRESS_CALIB_A, pa);
      write_calib(bprc_pkg::CSR_PRESS_CALIB_B, pb);
      write_calib(bprc_pkg::CSR_PRESS_CALIB_C, {48'hFFFF_FFFF_FFFF, pc});
   endtask

   // waits out the block, so calibration may change
   task automatic drain();
      do @(posedge clock);
      while (readings_pending.size() != 0 || results_expected.size() != 0);
      repeat (150) @(posedge clock);
   endtask

   task automatic queue_reading(logic [19:0] t, logic [19:0] p);
      bprc_pkg::req_type r;
      r.raw_temperature = t;
      r.raw_pressure    = p;
      readings_pending.push_back(r);
   endtask

   function automatic logic [15:0] jitter(logic [15:0] v);
      return v + 16'($urandom_range(64)) - 16'd32;
   endfunction

   // typical datasheet-like coefficients
   localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] TYP_PA = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] TYP_PB = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [15:0] TYP_PC = 16'd6000;

   initial begin
      int sel;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: divisor is zero, pressure invalid
      queue_reading(20'd0, 20'd0);
      queue_reading(20'hFFFFF, 20'hFFFFF);
      queue_reading(20'd0, 20'hFFFFF);
      drain();

      write_all(TYP_T, TYP_PA, TYP_PB, TYP_PC);
      queue_reading(20'd519888, 20'd415148);
      queue_reading(20'd0, 20'd0);
      queue_reading(20'hFFFFF, 20'hFFFFF);
      queue_reading(20'hFFFFF, 20'd0);
      queue_reading(20'd0, 20'hFFFFF);
      queue_reading(20'h80000, 20'h7FFFF);
      drain();

      // extreme coefficients
      write_all('1, '1, '1, '1);
      queue_reading(20'd0, 20'd0);
      queue_reading(20'hFFFFF, 20'hFFFFF);
      queue_reading(20'h55555, 20'hAAAAA);
      drain();
      write_all({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
      queue_reading(20'd0, 20'hFFFFF);
      queue_reading(20'hFFFFF, 20'd0);
      queue_reading(20'hAAAAA, 20'h55555);
      drain();
      write_all({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
      queue_reading(20'd0, 20'd0);
      queue_reading(20'hFFFFF, 20'hFFFFF);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         idle_mode = phase < 3 ? 0 : (phase < 6 ? 1 : 2);
         sel = $urandom_range(9);
         if (sel < 5)
            write_all({jitter(TYP_T[47:32]), jitter(TYP_T[31:16]), jitter(TYP_T[15:0])},
                      {jitter(TYP_PA[63:48]), jitter(TYP_PA[47:32]),
                       jitter(TYP_PA[31:16]), jitter(TYP_PA[15:0])},
                      {jitter(TYP_PB[63:48]), jitter(TYP_PB[47:32]),
                       jitter(TYP_PB[31:16]), jitter(TYP_PB[15:0])},
                      jitter(TYP_PC));
         else if (sel < 9)
            write_all(48'({$urandom, $urandom}), {$urandom, $urandom},
                      {$urandom, $urandom}, 16'($urandom));
         else
            write_all(48'({$urandom, $urandom}), {$urandom, 16'($urandom), 16'd0},
                      {$urandom, $urandom}, 16'($urandom));
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(1))
               queue_reading(20'($urandom_range(600000, 400000)),
                             20'($urandom_range(500000, 200000)));
            else
               queue_reading(20'($urandom), 20'($urandom));
         end
         drain();
      end

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
